@@ hdl/table_driven_dfa_acceptor_unit_assert.svh @@
// assertion macros used by the dfa acceptor top level
`ifndef TABLE_DRIVEN_DFA_ACCEPTOR_UNIT_ASSERT_SVH
`define TABLE_DRIVEN_DFA_ACCEPTOR_UNIT_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define TDFA_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dfa acceptor assertion failed");

// next-cycle implication, disabled while in reset
`define TDFA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dfa acceptor assertion failed");

`endif

@@ hdl/tdfa_pkg.sv @@
// types and constants of the dfa word acceptor
`timescale 1ns / 1ps

package tdfa_pkg;

   // field widths fixed by the item formats
   localparam int STATE_W   = 7;
   localparam int CHAR_W    = 8;
   localparam int SYM_IDX_W = 4;
   localparam int COUNT_W   = 5;
   localparam int ACC_W     = 64;
   localparam int ACC_IDX_W = 6;
   localparam int ALPHA_W   = 64;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 64;

   // default sizes
   localparam int DEF_MAX_STATES  = 64;
   localparam int DEF_MAX_SYMBOLS = 16;

   // item operation codes
   localparam logic OP_TABLE_WRITE = 1'b0;
   localparam logic OP_CHAR        = 1'b1;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START_STATE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEPTING   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SYM_COUNT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_LOW   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_HIGH  = 3'd4;

   typedef struct packed {
      logic                 op;
      logic [CHAR_W-1:0]    symbol_char;
      logic                 last_char;
      logic [STATE_W-1:0]   row_state;
      logic [SYM_IDX_W-1:0] column_symbol;
      logic [STATE_W-1:0]   target_state;
   } req_item_type;

   typedef struct packed {
      logic               accepted;
      logic               bad_symbol;
      logic               bad_target;
      logic [STATE_W-1:0] end_state;
   } rsp_item_type;

   typedef struct packed {
      logic                 hit;
      logic [SYM_IDX_W-1:0] idx;
   } sym_match_type;

   typedef struct packed {
      logic [STATE_W-1:0] start_state;
      logic [ACC_W-1:0]   accepting_states;
      logic [COUNT_W-1:0] symbol_count;
      logic [ALPHA_W-1:0] alphabet_low;
      logic [ALPHA_W-1:0] alphabet_high;
   } cfg_type;

endpackage

@@ hdl/tdfa_ram.sv @@
// generic simple dual port ram with registered read
`timescale 1ns / 1ps

module tdfa_ram #(
   parameter int WIDTH = tdfa_pkg::STATE_W,
   parameter int DEPTH = tdfa_pkg::DEF_MAX_STATES * tdfa_pkg::DEF_MAX_SYMBOLS
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/tdfa_match.sv @@
// parallel alphabet compare, lowest matching symbol index wins
`timescale 1ns / 1ps

module tdfa_match #(
   parameter int MAX_SYMBOLS = tdfa_pkg::DEF_MAX_SYMBOLS
) (
   input  logic [tdfa_pkg::CHAR_W-1:0] symbol_char,
   input  tdfa_pkg::cfg_type           cfg,
   output tdfa_pkg::sym_match_type     match
);

   logic [tdfa_pkg::COUNT_W-1:0]     count_eff;
   logic [2*tdfa_pkg::ALPHA_W-1:0]   alphabet;

   // symbol count clamped to the table width
   always_comb begin
      if (cfg.symbol_count > tdfa_pkg::COUNT_W'(MAX_SYMBOLS)) begin
         count_eff = tdfa_pkg::COUNT_W'(MAX_SYMBOLS);
      end else begin
         count_eff = cfg.symbol_count;
      end
   end

   assign alphabet = {cfg.alphabet_high, cfg.alphabet_low};

   // scan from the top so the lowest match is the last one written
   always_comb begin
      match.hit = 1'b0;
      match.idx = '0;
      for (int j = MAX_SYMBOLS - 1; j >= 0; j--) begin
         if ((tdfa_pkg::COUNT_W'(j) < count_eff) &&
             (alphabet[j*tdfa_pkg::CHAR_W +: tdfa_pkg::CHAR_W] == symbol_char)) begin
            match.hit = 1'b1;
            match.idx = tdfa_pkg::SYM_IDX_W'(j);
         end
      end
   end

endmodule

@@ hdl/tdfa_walk.sv @@
// two-stage table walk: address and write stage, then resolve stage
`timescale 1ns / 1ps

module tdfa_walk #(
   parameter int MAX_STATES  = tdfa_pkg::DEF_MAX_STATES,
   parameter int MAX_SYMBOLS = tdfa_pkg::DEF_MAX_SYMBOLS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_accept,
   input  tdfa_pkg::req_item_type  in_item,
   input  tdfa_pkg::sym_match_type in_match,
   input  tdfa_pkg::cfg_type       cfg,
   input  logic                    out_hold,
   output logic                    ready,
   output logic                    res_valid,
   output tdfa_pkg::rsp_item_type  res_item
);

   localparam int DEPTH  = MAX_STATES * MAX_SYMBOLS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int SW     = tdfa_pkg::STATE_W;

   function automatic logic state_ok(input logic [SW-1:0] s);
      return (s != '0) && (s <= SW'(MAX_STATES));
   endfunction

   // stage 1 registers
   logic                    s1_valid_ff, s1_valid_in;
   tdfa_pkg::req_item_type  s1_item_ff, s1_item_in;
   tdfa_pkg::sym_match_type s1_match_ff, s1_match_in;

   // stage 2 registers
   logic          s2_valid_ff, s2_valid_in;
   logic          s2_last_ff, s2_last_in;
   logic          s2_lookup_ff, s2_lookup_in;
   logic [SW-1:0] s2_state_ff, s2_state_in;
   logic          s2_serr_ff, s2_serr_in;
   logic          s2_terr_ff, s2_terr_in;

   // committed word state
   logic          in_word_ff, in_word_in;
   logic [SW-1:0] cur_state_ff, cur_state_in;
   logic          serr_ff, serr_in;
   logic          terr_ff, terr_in;

   logic              advance;
   logic [SW-1:0]     rd_data;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;
   logic              rd_en;
   logic              wr_en;

   logic [SW-1:0] post_state;
   logic          post_serr;
   logic          post_terr;
   logic [SW-1:0] post_row;

   logic          fwd_in_word;
   logic [SW-1:0] fwd_state;
   logic          fwd_serr;
   logic          fwd_terr;

   logic          s1_char;
   logic          s1_write;
   logic [SW-1:0] pre_state;
   logic          pre_serr;
   logic          pre_terr;
   logic          pre_lookup;
   logic [SW-1:0] pre_row;
   logic [SW-1:0] wr_row;

   // the pipe only halts when a finished word meets a held output
   assign advance = !(s2_valid_ff && s2_last_ff && out_hold);
   assign ready   = advance;

   // resolve stage: table data gives the next state
   always_comb begin
      post_state = s2_state_ff;
      post_serr  = s2_serr_ff;
      post_terr  = s2_terr_ff;
      if (s2_lookup_ff) begin
         if (state_ok(rd_data)) begin
            post_state = rd_data;
         end else begin
            post_terr = 1'b1;
         end
      end
   end

   // forward the resolving item ahead of the committed state
   always_comb begin
      if (s2_valid_ff) begin
         fwd_in_word = !s2_last_ff;
         fwd_state   = post_state;
         fwd_serr    = post_serr;
         fwd_terr    = post_terr;
      end else begin
         fwd_in_word = in_word_ff;
         fwd_state   = cur_state_ff;
         fwd_serr    = serr_ff;
         fwd_terr    = terr_ff;
      end
   end

   // stage 1: word start, symbol check and table address
   always_comb begin
      s1_char  = s1_valid_ff && (s1_item_ff.op == tdfa_pkg::OP_CHAR);
      s1_write = s1_valid_ff && (s1_item_ff.op == tdfa_pkg::OP_TABLE_WRITE);
      if (fwd_in_word) begin
         pre_state = fwd_state;
         pre_serr  = fwd_serr;
         pre_terr  = fwd_terr;
      end else begin
         pre_state = cfg.start_state;
         pre_serr  = 1'b0;
         pre_terr  = !state_ok(cfg.start_state);
      end
      pre_lookup = 1'b0;
      if (!pre_serr && !pre_terr) begin
         if (s1_match_ff.hit) begin
            pre_lookup = 1'b1;
         end else begin
            pre_serr = 1'b1;
         end
      end
      pre_row = pre_state - SW'(1);
      rd_addr = ADDR_W'(ADDR_W'(pre_row) * ADDR_W'(MAX_SYMBOLS)
                + ADDR_W'(s1_match_ff.idx));
      rd_en   = s1_char && advance;
   end

   // table writes with the row and column in range
   always_comb begin
      wr_row  = s1_item_ff.row_state - SW'(1);
      wr_addr = ADDR_W'(ADDR_W'(wr_row) * ADDR_W'(MAX_SYMBOLS)
                + ADDR_W'(s1_item_ff.column_symbol));
      wr_en   = s1_write && advance && state_ok(s1_item_ff.row_state) &&
                ({1'b0, s1_item_ff.column_symbol} < tdfa_pkg::COUNT_W'(MAX_SYMBOLS));
   end

   tdfa_ram #(
      .WIDTH (SW),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (s1_item_ff.target_state),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // next values of the pipe and the committed state
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_item_in   = s1_item_ff;
      s1_match_in  = s1_match_ff;
      s2_valid_in  = s2_valid_ff;
      s2_last_in   = s2_last_ff;
      s2_lookup_in = s2_lookup_ff;
      s2_state_in  = s2_state_ff;
      s2_serr_in   = s2_serr_ff;
      s2_terr_in   = s2_terr_ff;
      in_word_in   = in_word_ff;
      cur_state_in = cur_state_ff;
      serr_in      = serr_ff;
      terr_in      = terr_ff;
      if (advance) begin
         s1_valid_in  = in_accept;
         s1_item_in   = in_item;
         s1_match_in  = in_match;
         s2_valid_in  = s1_char;
         s2_last_in   = s1_item_ff.last_char;
         s2_lookup_in = pre_lookup;
         s2_state_in  = pre_state;
         s2_serr_in   = pre_serr;
         s2_terr_in   = pre_terr;
         if (s2_valid_ff) begin
            in_word_in   = !s2_last_ff;
            cur_state_in = post_state;
            serr_in      = post_serr;
            terr_in      = post_terr;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         in_word_ff   <= 1'b0;
         cur_state_ff <= SW'(1);
         serr_ff      <= 1'b0;
         terr_ff      <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         in_word_ff   <= in_word_in;
         cur_state_ff <= cur_state_in;
         serr_ff      <= serr_in;
         terr_ff      <= terr_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_item_ff   <= s1_item_in;
      s1_match_ff  <= s1_match_in;
      s2_last_ff   <= s2_last_in;
      s2_lookup_ff <= s2_lookup_in;
      s2_state_ff  <= s2_state_in;
      s2_serr_ff   <= s2_serr_in;
      s2_terr_ff   <= s2_terr_in;
   end

   // result of a word on its last character
   always_comb begin
      post_row            = post_state - SW'(1);
      res_valid           = s2_valid_ff && s2_last_ff && advance;
      res_item.accepted   = !post_serr && !post_terr && state_ok(post_state) &&
                            cfg.accepting_states[post_row[tdfa_pkg::ACC_IDX_W-1:0]];
      res_item.bad_symbol = post_serr;
      res_item.bad_target = post_terr;
      res_item.end_state  = post_state;
   end

endmodule

@@ hdl/table_driven_dfa_acceptor_unit.sv @@
// Table-driven DFA word acceptor, top level.
//
// Channels: req_ carries one item per handshake (valid high, stall low).
// An item with op table-write stores one transition entry; an item with op
// char feeds one character of a word, last_char marking its end. rsp_ returns
// one item per word: accepted, bad_symbol, bad_target and end_state.
// csr_ writes the configuration registers; csr_ready is always high.
// Throughput: one item per clock while req_stall is low. The next-state
// loop goes through the transition ram read port; the following character's
// address is formed from the forwarded read data in the same cycle.
// Results: a word's last character passes stage 1, then stage 2, and its
// result is registered in the output register that drives rsp_valid.
// Stall: a held result only stops the pipe when another finished word is
// ready to leave; then req_stall rises until rsp_stall drops.
// Reset: configuration returns to start state 1 and an empty alphabet, the
// pipe empties and the next character starts a new word. The transition
// table is not cleared and must be written before it is used.
`timescale 1ns / 1ps
`include "table_driven_dfa_acceptor_unit_assert.svh"

module table_driven_dfa_acceptor_unit #(
   parameter int MAX_STATES  = tdfa_pkg::DEF_MAX_STATES,
   parameter int MAX_SYMBOLS = tdfa_pkg::DEF_MAX_SYMBOLS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  tdfa_pkg::req_item_type            req_item,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output tdfa_pkg::rsp_item_type            rsp_item,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tdfa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tdfa_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   tdfa_pkg::cfg_type       cfg_ff, cfg_in;
   tdfa_pkg::sym_match_type req_match;
   tdfa_pkg::rsp_item_type  res_item;
   tdfa_pkg::rsp_item_type  rsp_item_ff, rsp_item_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    res_valid;
   logic                    walk_ready;
   logic                    req_accept;

   assign csr_ready = 1'b1;

   // configuration register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            tdfa_pkg::CSR_START_STATE:
               cfg_in.start_state = csr_wdata[tdfa_pkg::STATE_W-1:0];
            tdfa_pkg::CSR_ACCEPTING:
               cfg_in.accepting_states = csr_wdata[tdfa_pkg::ACC_W-1:0];
            tdfa_pkg::CSR_SYM_COUNT:
               cfg_in.symbol_count = csr_wdata[tdfa_pkg::COUNT_W-1:0];
            tdfa_pkg::CSR_ALPHA_LOW:
               cfg_in.alphabet_low = csr_wdata[tdfa_pkg::ALPHA_W-1:0];
            tdfa_pkg::CSR_ALPHA_HIGH:
               cfg_in.alphabet_high = csr_wdata[tdfa_pkg::ALPHA_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_state      <= tdfa_pkg::STATE_W'(1);
         cfg_ff.accepting_states <= '0;
         cfg_ff.symbol_count     <= '0;
         cfg_ff.alphabet_low     <= '0;
         cfg_ff.alphabet_high    <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // symbol lookup on the incoming character
   tdfa_match #(
      .MAX_SYMBOLS (MAX_SYMBOLS)
   ) u_match (
      .symbol_char (req_item.symbol_char),
      .cfg         (cfg_ff),
      .match       (req_match)
   );

   assign req_stall  = !walk_ready;
   assign req_accept = req_valid && !req_stall;

   // table walk pipeline
   tdfa_walk #(
      .MAX_STATES  (MAX_STATES),
      .MAX_SYMBOLS (MAX_SYMBOLS)
   ) u_walk (
      .clock     (clock),
      .reset     (reset),
      .in_accept (req_accept),
      .in_item   (req_item),
      .in_match  (req_match),
      .cfg       (cfg_ff),
      .out_hold  (rsp_valid_ff && rsp_stall),
      .ready     (walk_ready),
      .res_valid (res_valid),
      .res_item  (res_item)
   );

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_item_in  = rsp_item_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = res_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // a new result never lands on a held one
   `TDFA_ASSERT_NOW(a_no_overwrite, clock, reset, rsp_valid_ff && rsp_stall, !res_valid)
   // input stalls only behind a held result
   `TDFA_ASSERT_NOW(a_stall_cause, clock, reset, req_stall, rsp_valid_ff && rsp_stall)
   // a dead word is never accepted and carries one error at most
   `TDFA_ASSERT_NOW(a_err_excl, clock, reset, rsp_valid,
                    !(rsp_item.bad_symbol && rsp_item.bad_target))
   `TDFA_ASSERT_NOW(a_acc_clean, clock, reset, rsp_valid && rsp_item.accepted,
                    !rsp_item.bad_symbol && !rsp_item.bad_target)

endmodule

@@ test/table_driven_dfa_acceptor_unit_test.sv @@
// self-checking testbench for the table-driven dfa word acceptor
`timescale 1ns / 1ps

module table_driven_dfa_acceptor_unit_test;

   localparam int NUM_SYMBOLS = tdfa_pkg::DEF_MAX_SYMBOLS;
   localparam int NUM_STATES  = tdfa_pkg::DEF_MAX_STATES;
   localparam int TAB_DEPTH   = NUM_STATES * NUM_SYMBOLS;
   localparam int ITEM_W      = $bits(tdfa_pkg::req_item_type);
   localparam int ITEM_GOAL   = 950;
   localparam int CYCLE_LIMIT = 400000;

   logic                            clock;
   logic                            reset = 1'b1;
   logic                            req_valid;
   logic                            req_stall;
   tdfa_pkg::req_item_type          req_item;
   logic                            rsp_valid;
   logic                            rsp_stall;
   tdfa_pkg::rsp_item_type          rsp_item;
   logic                            csr_valid;
   logic                            csr_ready;
   logic [tdfa_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [tdfa_pkg::CSR_DATA_W-1:0] csr_wdata;

   table_driven_dfa_acceptor_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow of the acceptor: configuration, transition entries, word state
   logic [tdfa_pkg::STATE_W-1:0] cfg_start = 7'd1;
   logic [tdfa_pkg::ACC_W-1:0]   cfg_acc   = '0;
   logic [tdfa_pkg::COUNT_W-1:0] cfg_count = '0;
   logic [tdfa_pkg::ALPHA_W-1:0] cfg_alo   = '0;
   logic [tdfa_pkg::ALPHA_W-1:0] cfg_ahi   = '0;
   logic [tdfa_pkg::STATE_W-1:0] trans_tab [0:TAB_DEPTH-1];
   bit                           trans_known [0:TAB_DEPTH-1];
   logic [tdfa_pkg::STATE_W-1:0] cur_state = 7'd1;
   bit                           in_word, sym_err, tgt_err;

   tdfa_pkg::rsp_item_type verdict_q [$];
   int                     live_rows [$];
   int                     errors = 0;
   int                     items_sent = 0;
   int                     cycle_count = 0;
   bit                     calm = 1'b0;

   // directed stimulus rows
   typedef struct {
      bit                              is_csr;
      logic [tdfa_pkg::CSR_IDX_W-1:0]  idx;
      logic [tdfa_pkg::CSR_DATA_W-1:0] data;
      tdfa_pkg::req_item_type          item;
      bit                              typed;
      tdfa_pkg::rsp_item_type          want;
   } plan_step_type;

   plan_step_type plan_q [$];

   function automatic bit state_ok(input logic [tdfa_pkg::STATE_W-1:0] s);
      return s >= 1 && s <= NUM_STATES;
   endfunction

   function automatic int eff_count();
      return (cfg_count > NUM_SYMBOLS) ? NUM_SYMBOLS : int'(cfg_count);
   endfunction

   function automatic logic [tdfa_pkg::CHAR_W-1:0] sym_byte(input int j);
      if (j < 8) return cfg_alo[8*j +: 8];
      return cfg_ahi[8*(j-8) +: 8];
   endfunction

   // lowest alphabet index matching the character, -1 when none does
   function automatic int find_symbol(input logic [tdfa_pkg::CHAR_W-1:0] ch);
      for (int j = 0; j < eff_count(); j++)
         if (sym_byte(j) == ch) return j;
      return -1;
   endfunction

   function automatic void apply_csr(input logic [tdfa_pkg::CSR_IDX_W-1:0] idx,
                                     input logic [tdfa_pkg::CSR_DATA_W-1:0] data);
      case (idx)
         tdfa_pkg::CSR_START_STATE: cfg_start = data[tdfa_pkg::STATE_W-1:0];
         tdfa_pkg::CSR_ACCEPTING:   cfg_acc = data;
         tdfa_pkg::CSR_SYM_COUNT:   cfg_count = data[tdfa_pkg::COUNT_W-1:0];
         tdfa_pkg::CSR_ALPHA_LOW:   cfg_alo = data;
         tdfa_pkg::CSR_ALPHA_HIGH:  cfg_ahi = data;
         default: ;
      endcase
   endfunction

   // writes outside the state range are dropped
   function automatic void store_entry(input logic [tdfa_pkg::STATE_W-1:0] row,
                                       input logic [tdfa_pkg::SYM_IDX_W-1:0] col,
                                       input logic [tdfa_pkg::STATE_W-1:0] tgt);
      int a;
      if (state_ok(row)) begin
         a = (int'(row) - 1) * NUM_SYMBOLS + int'(col);
         trans_tab[a] = tgt;
         trans_known[a] = 1'b1;
      end
   endfunction

   // one character through the automaton; returns 1 when the word ends
   function automatic bit advance_dfa(input logic [tdfa_pkg::CHAR_W-1:0] ch,
                                      input logic last,
                                      output tdfa_pkg::rsp_item_type v);
      int idx;
      logic [tdfa_pkg::STATE_W-1:0] nxt;
      v = '0;
      if (!in_word) begin
         in_word = 1'b1;
         cur_state = cfg_start;
         sym_err = 1'b0;
         tgt_err = !state_ok(cfg_start);
      end
      if (!sym_err && !tgt_err) begin
         idx = find_symbol(ch);
         if (idx < 0) begin
            sym_err = 1'b1;
         end else begin
            nxt = trans_tab[(int'(cur_state) - 1) * NUM_SYMBOLS + idx];
            if (state_ok(nxt)) cur_state = nxt;
            else tgt_err = 1'b1;
         end
      end
      if (!last) return 1'b0;
      if (!sym_err && !tgt_err && state_ok(cur_state))
         v.accepted = cfg_acc[int'(cur_state) - 1];
      v.bad_symbol = sym_err;
      v.bad_target = tgt_err;
      v.end_state  = cur_state;
      in_word = 1'b0;
      sym_err = 1'b0;
      tgt_err = 1'b0;
      cur_state = cfg_start;
      return 1'b1;
   endfunction

   // true when the character reads no entry that was never written
   function automatic bit char_safe(input logic [tdfa_pkg::CHAR_W-1:0] ch);
      logic [tdfa_pkg::STATE_W-1:0] s;
      bit dead;
      int idx;
      if (!in_word) begin
         s = cfg_start;
         dead = !state_ok(cfg_start);
      end else begin
         s = cur_state;
         dead = sym_err || tgt_err;
      end
      if (dead) return 1'b1;
      idx = find_symbol(ch);
      if (idx < 0) return 1'b1;
      return trans_known[(int'(s) - 1) * NUM_SYMBOLS + idx];
   endfunction

   // mostly alphabet members, falling back to a random character when unsafe
   function automatic logic [tdfa_pkg::CHAR_W-1:0] pick_char();
      logic [tdfa_pkg::CHAR_W-1:0] ch;
      if (eff_count() > 0 && $urandom_range(0, 9) < 8)
         ch = sym_byte($urandom_range(0, eff_count() - 1));
      else
         ch = tdfa_pkg::CHAR_W'($urandom_range(0, 255));
      while (!char_safe(ch)) ch = tdfa_pkg::CHAR_W'($urandom_range(0, 255));
      return ch;
   endfunction

   function automatic int pick_target();
      if ($urandom_range(0, 7) == 0)
         return $urandom_range(0, 1) ? 0 : $urandom_range(NUM_STATES + 1, 127);
      return live_rows[$urandom_range(0, live_rows.size() - 1)];
   endfunction

   // unused fields carry random bits
   function automatic tdfa_pkg::req_item_type make_entry(input int row, input int col,
                                                         input int tgt);
      logic [31:0] raw;
      tdfa_pkg::req_item_type it;
      raw = $urandom;
      it = raw[ITEM_W-1:0];
      it.op = tdfa_pkg::OP_TABLE_WRITE;
      it.row_state = tdfa_pkg::STATE_W'(row);
      it.column_symbol = tdfa_pkg::SYM_IDX_W'(col);
      it.target_state = tdfa_pkg::STATE_W'(tgt);
      return it;
   endfunction

   function automatic tdfa_pkg::req_item_type make_char(
         input logic [tdfa_pkg::CHAR_W-1:0] ch, input logic last);
      logic [31:0] raw;
      tdfa_pkg::req_item_type it;
      raw = $urandom;
      it = raw[ITEM_W-1:0];
      it.op = tdfa_pkg::OP_CHAR;
      it.symbol_char = ch;
      it.last_char = last;
      return it;
   endfunction

   function automatic tdfa_pkg::rsp_item_type verdict(input bit a, input bit bs,
                                                      input bit bt, input int es);
      tdfa_pkg::rsp_item_type v;
      v.accepted = a;
      v.bad_symbol = bs;
      v.bad_target = bt;
      v.end_state = tdfa_pkg::STATE_W'(es);
      return v;
   endfunction

   function automatic void plan_csr(input logic [tdfa_pkg::CSR_IDX_W-1:0] idx,
                                    input logic [tdfa_pkg::CSR_DATA_W-1:0] data);
      plan_step_type s;
      s.is_csr = 1'b1;
      s.idx = idx;
      s.data = data;
      s.item = '0;
      s.typed = 1'b0;
      s.want = '0;
      plan_q.push_back(s);
   endfunction

   function automatic void plan_item(input tdfa_pkg::req_item_type it, input bit typed,
                                     input tdfa_pkg::rsp_item_type want);
      plan_step_type s;
      s.is_csr = 1'b0;
      s.idx = tdfa_pkg::CSR_START_STATE;
      s.data = '0;
      s.item = it;
      s.typed = typed;
      s.want = want;
      plan_q.push_back(s);
   endfunction

   // a word character; the last one carries the expected verdict
   function automatic void plan_char(input logic [tdfa_pkg::CHAR_W-1:0] ch,
                                     input logic last,
                                     input tdfa_pkg::rsp_item_type want);
      plan_item(make_char(ch, last), last, want);
   endfunction

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // result side back-pressure in bursts
   initial begin
      rsp_stall = 1'b0;
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // compare each taken result with the oldest expectation
   always @(posedge clock) begin
      tdfa_pkg::rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (verdict_q.size() == 0) begin
            $error("result item with none expected: %p", rsp_item);
            errors++;
         end else begin
            want = verdict_q.pop_front();
            if (rsp_item.accepted !== want.accepted) begin
               $error("accepted: expected %0d, got %0d", want.accepted, rsp_item.accepted);
               errors++;
            end
            if (rsp_item.bad_symbol !== want.bad_symbol) begin
               $error("bad_symbol: expected %0d, got %0d", want.bad_symbol,
                      rsp_item.bad_symbol);
               errors++;
            end
            if (rsp_item.bad_target !== want.bad_target) begin
               $error("bad_target: expected %0d, got %0d", want.bad_target,
                      rsp_item.bad_target);
               errors++;
            end
            if (rsp_item.end_state !== want.end_state) begin
               $error("end_state: expected %0d, got %0d", want.end_state,
                      rsp_item.end_state);
               errors++;
            end
         end
      end
   end

   // one csr write; the caller lowers csr_valid after the last one
   task automatic csr_write(input logic [tdfa_pkg::CSR_IDX_W-1:0] idx,
                            input logic [tdfa_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      apply_csr(idx, data);
   endtask

   // hand over one item, then update the shadow and queue its verdict
   task automatic send_item(input tdfa_pkg::req_item_type it, input bit typed,
                            input tdfa_pkg::rsp_item_type want);
      tdfa_pkg::rsp_item_type v;
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (req_stall);
      items_sent++;
      if (it.op == tdfa_pkg::OP_TABLE_WRITE)
         store_entry(it.row_state, it.column_symbol, it.target_state);
      else if (advance_dfa(it.symbol_char, it.last_char, v))
         verdict_q.push_back(typed ? want : v);
   endtask

   // let the pipe empty before touching configuration
   task automatic settle();
      req_valid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // new configuration and table rows, then random words
   task automatic run_phase(input int phase);
      int nrows, n, budget, first_item, len;
      logic [tdfa_pkg::ALPHA_W-1:0] alo, ahi;
      logic [tdfa_pkg::CHAR_W-1:0] b;
      logic [tdfa_pkg::ACC_W-1:0] acc;
      logic [tdfa_pkg::COUNT_W-1:0] cnt;
      logic [tdfa_pkg::STATE_W-1:0] st;
      tdfa_pkg::req_item_type it;
      logic [31:0] raw;
      settle();

      // state set reached by this phase's words
      live_rows.delete();
      nrows = $urandom_range(1, 5);
      repeat (nrows) live_rows.push_back($urandom_range(1, NUM_STATES));
      if (phase % 3 == 0) live_rows[0] = 1;
      else if (phase % 3 == 1) live_rows[0] = NUM_STATES;

      if (phase % 6 == 5)
         st = $urandom_range(0, 1) ? 7'd0
                                   : tdfa_pkg::STATE_W'($urandom_range(NUM_STATES + 1, 127));
      else
         st = tdfa_pkg::STATE_W'(live_rows[0]);
      case (phase % 4)
         0: acc = '1;
         1: acc = '0;
         default: acc = {$urandom, $urandom};
      endcase
      case (phase % 5)
         0: cnt = tdfa_pkg::COUNT_W'(NUM_SYMBOLS);
         1: cnt = tdfa_pkg::COUNT_W'($urandom_range(NUM_SYMBOLS + 1, 31));
         2: cnt = 5'd1;
         default: cnt = tdfa_pkg::COUNT_W'($urandom_range(2, NUM_SYMBOLS));
      endcase
      // a narrow byte pool now and then gives duplicate symbols
      for (int j = 0; j < 16; j++) begin
         b = ($urandom_range(0, 3) == 0) ? tdfa_pkg::CHAR_W'($urandom_range(0, 3))
                                         : tdfa_pkg::CHAR_W'($urandom_range(0, 255));
         if (j < 8) alo[8*j +: 8] = b;
         else ahi[8*(j-8) +: 8] = b;
      end
      csr_write(tdfa_pkg::CSR_START_STATE, tdfa_pkg::CSR_DATA_W'(st));
      csr_write(tdfa_pkg::CSR_ACCEPTING, acc);
      csr_write(tdfa_pkg::CSR_SYM_COUNT, tdfa_pkg::CSR_DATA_W'(cnt));
      csr_write(tdfa_pkg::CSR_ALPHA_LOW, alo);
      csr_write(tdfa_pkg::CSR_ALPHA_HIGH, ahi);
      csr_valid <= 1'b0;

      // fill every column in use for the live rows
      n = eff_count();
      foreach (live_rows[k])
         for (int c = 0; c < n; c++)
            send_item(make_entry(live_rows[k], c, pick_target()), 1'b0, '0);

      // words with the odd table write mixed in
      budget = $urandom_range(50, 110);
      first_item = items_sent;
      while (items_sent - first_item < budget && items_sent < ITEM_GOAL) begin
         if ($urandom_range(0, 9) == 0) begin
            raw = $urandom;
            it = raw[ITEM_W-1:0];
            it.op = tdfa_pkg::OP_TABLE_WRITE;
            if ($urandom_range(0, 3) != 0) begin
               it.row_state =
                  tdfa_pkg::STATE_W'(live_rows[$urandom_range(0, live_rows.size() - 1)]);
               it.target_state = tdfa_pkg::STATE_W'(pick_target());
            end
            send_item(it, 1'b0, '0);
         end else begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
               send_item(make_char(pick_char(), i == len - 1), 1'b0, '0);
         end
      end
   endtask

   // reset, directed rows, random phases, drain
   initial begin
      bit csr_open, items_open;
      int phase;
      req_valid = 1'b0;
      req_item = '0;
      csr_valid = 1'b0;
      csr_index = tdfa_pkg::CSR_START_STATE;
      csr_wdata = '0;
      csr_open = 1'b0;
      items_open = 1'b0;

      // out of reset the alphabet is empty, so any character is foreign
      plan_char(8'h61, 1'b1, verdict(0, 1, 0, 1));
      // states 1 and 64 accept; count above the maximum; symbol 8 repeats symbol 1
      plan_csr(tdfa_pkg::CSR_START_STATE, 64'd1);
      plan_csr(tdfa_pkg::CSR_ACCEPTING, 64'h8000_0000_0000_0001);
      plan_csr(tdfa_pkg::CSR_SYM_COUNT, 64'd31);
      plan_csr(tdfa_pkg::CSR_ALPHA_LOW, 64'h0706_0504_0362_6100);
      plan_csr(tdfa_pkg::CSR_ALPHA_HIGH, 64'hFF0E_0D0C_0B0A_0961);
      plan_item(make_entry(1, 0, 64), 1'b0, '0);
      plan_item(make_entry(64, 15, 1), 1'b0, '0);
      plan_item(make_entry(1, 1, 2), 1'b0, '0);
      plan_item(make_entry(1, 8, 0), 1'b0, '0);
      plan_item(make_entry(2, 2, 127), 1'b0, '0);
      plan_item(make_entry(64, 0, 64), 1'b0, '0);
      // out-of-range rows must not land on rows 1 or 64
      plan_item(make_entry(65, 1, 0), 1'b0, '0);
      plan_item(make_entry(0, 15, 0), 1'b0, '0);
      plan_item(make_entry(127, 15, 127), 1'b0, '0);
      plan_char(8'h00, 1'b1, verdict(1, 0, 0, 64));
      plan_char(8'h00, 1'b0, '0);
      plan_char(8'hFF, 1'b1, verdict(1, 0, 0, 1));
      // duplicate symbol resolves to the lower index
      plan_char(8'h61, 1'b1, verdict(0, 0, 0, 2));
      // bad target keeps the last good state
      plan_char(8'h61, 1'b0, '0);
      plan_char(8'h62, 1'b1, verdict(0, 0, 1, 2));
      plan_char(8'h7A, 1'b1, verdict(0, 1, 0, 1));
      // dead word ignores the rest
      plan_char(8'h61, 1'b0, '0);
      plan_char(8'h7A, 1'b0, '0);
      plan_char(8'h62, 1'b1, verdict(0, 1, 0, 2));
      // start states outside the range, then the top state
      plan_csr(tdfa_pkg::CSR_START_STATE, 64'd0);
      plan_char(8'h61, 1'b1, verdict(0, 0, 1, 0));
      plan_csr(tdfa_pkg::CSR_START_STATE, 64'd127);
      plan_char(8'h00, 1'b1, verdict(0, 0, 1, 127));
      plan_csr(tdfa_pkg::CSR_START_STATE, 64'd64);
      plan_char(8'hFF, 1'b1, verdict(1, 0, 0, 1));

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (plan_q[i]) begin
         if (plan_q[i].is_csr) begin
            if (items_open) begin
               settle();
               items_open = 1'b0;
            end
            csr_write(plan_q[i].idx, plan_q[i].data);
            csr_open = 1'b1;
         end else begin
            if (csr_open) begin
               csr_valid <= 1'b0;
               csr_open = 1'b0;
            end
            send_item(plan_q[i].item, plan_q[i].typed, plan_q[i].want);
            items_open = 1'b1;
         end
      end

      phase = 0;
      while (items_sent < ITEM_GOAL) begin
         calm = (items_sent >= ITEM_GOAL - 150);
         run_phase(phase);
         phase++;
      end

      req_valid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (errors == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule
